### hw/rtl/ttb_pkg.sv
`default_nettype none
package ttb_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned UvW   = 20;
  localparam int unsigned OutW  = 32;
  localparam int unsigned FracW = 16;

  localparam int unsigned EW   = PosW + 1;          // edge delta
  localparam int unsigned DW   = UvW + 1;           // uv delta
  localparam int unsigned PW   = EW + DW;           // numerator product
  localparam int unsigned NW   = PW + 1;            // numerator
  localparam int unsigned DPW  = 2 * DW;            // det product
  localparam int unsigned DETW = DPW + 1;           // determinant
  localparam int unsigned QW   = OutW + 1;          // quotient bits developed
  localparam int unsigned DVW  = NW - 1 + FracW;    // |num| << 16
  localparam int unsigned RW   = DETW;              // remainder
  localparam int unsigned CntW = $clog2(QW + 1);
  localparam int unsigned Lanes = 6;
  localparam int unsigned QDepth = 2;

  localparam int unsigned InDataW  = 3 * PosW + 2 * UvW;
  localparam int unsigned OutDataW = 6 * OutW;

  typedef struct packed {
    logic signed [2:0][EW-1:0] e1;
    logic signed [2:0][EW-1:0] e2;
    logic signed [DW-1:0]      du1;
    logic signed [DW-1:0]      dv1;
    logic signed [DW-1:0]      du2;
    logic signed [DW-1:0]      dv2;
  } tri_t;

  typedef struct packed {
    logic [Lanes-1:0][OutW-1:0] vec;
    logic                       degenerate;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/ttb_front.sv
`default_nettype none
module ttb_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [ttb_pkg::InDataW-1:0]       in_data_i,
  input  wire                               q_full_i,
  output logic                              q_push_o,
  output ttb_pkg::tri_t                     q_data_o
);

  logic [1:0] phase_q, phase_d;
  logic signed [ttb_pkg::PosW-1:0] p0_q [3];
  logic signed [ttb_pkg::PosW-1:0] p1_q [3];
  logic signed [ttb_pkg::UvW-1:0]  u0_q, v0_q, u1_q, v1_q;
  logic signed [ttb_pkg::PosW-1:0] pin [3];
  logic signed [ttb_pkg::UvW-1:0]  uin, vin;
  logic acc;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pin[j] = in_data_i[j*ttb_pkg::PosW +: ttb_pkg::PosW];
    end
    uin = in_data_i[3*ttb_pkg::PosW +: ttb_pkg::UvW];
    vin = in_data_i[3*ttb_pkg::PosW+ttb_pkg::UvW +: ttb_pkg::UvW];
  end

  assign in_ready_o = (phase_q != 2'd2) || !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign q_push_o   = acc && (phase_q == 2'd2);

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      phase_d = (phase_q == 2'd0) ? 2'd1 : (phase_q == 2'd1) ? 2'd2 : 2'd0;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      q_data_o.e1[j] = ttb_pkg::EW'(p1_q[j]) - ttb_pkg::EW'(p0_q[j]);
      q_data_o.e2[j] = ttb_pkg::EW'(pin[j]) - ttb_pkg::EW'(p0_q[j]);
    end
    q_data_o.du1 = ttb_pkg::DW'(u1_q) - ttb_pkg::DW'(u0_q);
    q_data_o.dv1 = ttb_pkg::DW'(v1_q) - ttb_pkg::DW'(v0_q);
    q_data_o.du2 = ttb_pkg::DW'(uin) - ttb_pkg::DW'(u0_q);
    q_data_o.dv2 = ttb_pkg::DW'(vin) - ttb_pkg::DW'(v0_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) begin
        p0_q[j] <= '0;
        p1_q[j] <= '0;
      end
      u0_q <= '0; v0_q <= '0; u1_q <= '0; v1_q <= '0;
    end else if (acc && phase_q == 2'd0) begin
      for (int j = 0; j < 3; j++) p0_q[j] <= pin[j];
      u0_q <= uin;
      v0_q <= vin;
    end else if (acc && phase_q == 2'd1) begin
      for (int j = 0; j < 3; j++) p1_q[j] <= pin[j];
      u1_q <= uin;
      v1_q <= vin;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ttb_queue.sv
`default_nettype none
module ttb_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire ttb_pkg::tri_t  push_data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output ttb_pkg::tri_t       pop_data_o
);

  ttb_pkg::tri_t mem_q [ttb_pkg::QDepth];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(ttb_pkg::QDepth));
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ttb_back.sv
`default_nettype none
module ttb_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  output logic                q_pop_o,
  input  wire ttb_pkg::tri_t  q_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ttb_pkg::res_t       out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SUB  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  localparam int unsigned L = ttb_pkg::Lanes;

  state_e state_q, state_d;
  ttb_pkg::tri_t t_q;
  logic signed [ttb_pkg::PW-1:0]   pa_q [L];
  logic signed [ttb_pkg::PW-1:0]   pb_q [L];
  logic signed [ttb_pkg::DPW-1:0]  da_q, db_q;
  logic signed [ttb_pkg::NW-1:0]   num_q [L];
  logic signed [ttb_pkg::DETW-1:0] det_q;
  logic [ttb_pkg::RW-1:0]          dabs_q;
  logic [ttb_pkg::RW-1:0]          rem_q [L];
  logic [ttb_pkg::QW-1:0]          low_q [L];
  logic [ttb_pkg::QW-1:0]          quo_q [L];
  logic [L-1:0]                    neg_q, sat_q;
  logic                            deg_q;
  logic [ttb_pkg::CntW-1:0]        cnt_q;
  logic                            ov_q;
  ttb_pkg::res_t                   res_q, res_d;
  logic                            load;

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign load        = (state_q == S_DONE) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (!q_empty_i) state_d = S_MUL;
      S_MUL:  state_d = S_SUB;
      S_SUB:  state_d = S_PREP;
      S_PREP: state_d = (det_q == '0) ? S_DONE : S_DIV;
      S_DIV:  if (cnt_q == ttb_pkg::CntW'(1)) state_d = S_DONE;
      S_DONE: if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // zero a degenerate result, else saturate and apply sign to the quotient
  always_comb begin
    res_d.degenerate = deg_q;
    for (int k = 0; k < L; k++) begin
      if (deg_q) begin
        res_d.vec[k] = '0;
      end else if (!neg_q[k]) begin
        res_d.vec[k] = (sat_q[k] || quo_q[k] > ttb_pkg::QW'(33'h07FFFFFFF))
                       ? 32'h7FFFFFFF : quo_q[k][ttb_pkg::OutW-1:0];
      end else begin
        res_d.vec[k] = (sat_q[k] || quo_q[k] > ttb_pkg::QW'(33'h080000000))
                       ? 32'h80000000 : (32'd0 - quo_q[k][ttb_pkg::OutW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [ttb_pkg::NW-2:0]  nabs;
    logic [ttb_pkg::DVW-1:0] dvd;
    logic [ttb_pkg::RW:0]    r2;
    if (q_pop_o) t_q <= q_data_i;
    if (load) res_q <= res_d;
    unique case (state_q)
      S_MUL: begin
        da_q <= ttb_pkg::DPW'(t_q.du1) * ttb_pkg::DPW'(t_q.dv2);
        db_q <= ttb_pkg::DPW'(t_q.du2) * ttb_pkg::DPW'(t_q.dv1);
        // elements of a packed array select unsigned
        for (int j = 0; j < 3; j++) begin
          pa_q[j]   <= ttb_pkg::PW'($signed(t_q.e1[j])) * ttb_pkg::PW'(t_q.dv2);
          pb_q[j]   <= ttb_pkg::PW'($signed(t_q.e2[j])) * ttb_pkg::PW'(t_q.dv1);
          pa_q[3+j] <= ttb_pkg::PW'($signed(t_q.e2[j])) * ttb_pkg::PW'(t_q.du1);
          pb_q[3+j] <= ttb_pkg::PW'($signed(t_q.e1[j])) * ttb_pkg::PW'(t_q.du2);
        end
      end
      S_SUB: begin
        det_q <= ttb_pkg::DETW'(da_q) - ttb_pkg::DETW'(db_q);
        for (int k = 0; k < L; k++) begin
          num_q[k] <= ttb_pkg::NW'(pa_q[k]) - ttb_pkg::NW'(pb_q[k]);
        end
      end
      S_PREP: begin
        deg_q  <= (det_q == '0);
        dabs_q <= det_q[ttb_pkg::DETW-1] ? ttb_pkg::RW'(-det_q) : ttb_pkg::RW'(det_q);
        cnt_q  <= ttb_pkg::CntW'(ttb_pkg::QW);
        for (int k = 0; k < L; k++) begin
          nabs = (ttb_pkg::NW-1)'(num_q[k][ttb_pkg::NW-1] ? -num_q[k] : num_q[k]);
          dvd  = {nabs, ttb_pkg::FracW'(0)};
          neg_q[k] <= num_q[k][ttb_pkg::NW-1] ^ det_q[ttb_pkg::DETW-1];
          // quotient at or above 2^33: saturate regardless
          sat_q[k] <= (ttb_pkg::DVW+ttb_pkg::QW)'(dvd) >=
                      ((ttb_pkg::DVW+ttb_pkg::QW)'(det_q[ttb_pkg::DETW-1]
                        ? ttb_pkg::RW'(-det_q) : ttb_pkg::RW'(det_q)) << ttb_pkg::QW);
          rem_q[k] <= ttb_pkg::RW'(dvd[ttb_pkg::DVW-1:ttb_pkg::QW]);
          low_q[k] <= dvd[ttb_pkg::QW-1:0];
          quo_q[k] <= '0;
        end
      end
      S_DIV: begin
        cnt_q <= cnt_q - ttb_pkg::CntW'(1);
        for (int k = 0; k < L; k++) begin
          r2 = {rem_q[k], low_q[k][ttb_pkg::QW-1]};
          low_q[k] <= {low_q[k][ttb_pkg::QW-2:0], 1'b0};
          if (r2 >= {1'b0, dabs_q}) begin
            rem_q[k] <= ttb_pkg::RW'(r2 - {1'b0, dabs_q});
            quo_q[k] <= {quo_q[k][ttb_pkg::QW-2:0], 1'b1};
          end else begin
            rem_q[k] <= ttb_pkg::RW'(r2);
            quo_q[k] <= {quo_q[k][ttb_pkg::QW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/triangle_tangent_bitangent_top.sv
// Vertices are taken one per cycle unless a completed triangle finds the queue full;
// every third completes a triangle that is queued. Per triangle the back end runs
// multiply, subtract, prepare, then 33 restoring-division steps in six parallel
// lanes, then the output register; it pops the next triangle only once back in idle.
// A degenerate triangle skips the division.
// Asynchronous active-low reset clears the vertex phase, held vertices and queue.
`default_nettype none
module triangle_tangent_bitangent_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [135:0] s_axis_tdata_i,  // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [191:0] m_axis_tdata_o,  // tangent_x/y/z, bitangent_x/y/z
  output logic [0:0]   m_axis_tuser_o   // degenerate
);

  ttb_pkg::tri_t    push_data, pop_data;
  logic push, full;
  logic empty, pop;
  ttb_pkg::res_t res;

  ttb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  ttb_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  ttb_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i   (empty),
    .q_pop_o     (pop),
    .q_data_i    (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  always_comb begin
    for (int k = 0; k < ttb_pkg::Lanes; k++) begin
      m_axis_tdata_o[k*ttb_pkg::OutW +: ttb_pkg::OutW] = res.vec[k];
    end
    m_axis_tuser_o = res.degenerate;
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("degenerate result with nonzero vectors");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
